### rtl/awss_pkg.sv
// shared types and constants of the affinity work-stealing chunk scheduler
package awss_pkg;

	// worker count register width, apb address and data widths, register reset values
	localparam int WIU_W         = 4;
	localparam int PADDR_W       = 3;
	localparam int APB_DW        = 32;
	localparam int TOTAL_RESET   = 1024;
	localparam int WORKERS_RESET = 8;

	// command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// register index, taken from paddr above the byte offset
	typedef logic [PADDR_W-3:0] reg_idx_t;
	localparam reg_idx_t REG_TOTAL_ITER = 1'b0;
	localparam reg_idx_t REG_WORKERS    = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_ST_EACH,
		ST_ST_RANGE,
		ST_ST_EMIT,
		ST_FN_READ,
		ST_FN_CHUNK,
		ST_SR_READ,
		ST_SR_CMP,
		ST_SR_END,
		ST_SL_FIND,
		ST_SL_EMIT
	} state_t;

endpackage

### rtl/affinity_work_stealing_scheduler.sv
// affinity loop scheduler with work stealing: top level
//
// command channel (cmd_valid / cmd_stall, fields command and worker_id): a start
// word splits total_iterations into workers_in_use equal ranges and returns one
// result word per worker, the last of them marked with last. a finished word
// from a worker returns exactly one result word: its next chunk, a chunk stolen
// from the busiest worker (lowest index on ties), or all_done. a finished word
// from a worker index not in use is taken and returns nothing.
// result channel (res_valid / res_stall): one output register; while the
// receiver stalls, the word holds and the sequencer waits before the next one.
// every ceil division runs on one shared restoring divider, one quotient bit a
// cycle, and that divider sets the timing. the busiest-worker search reads one
// worker at a time from the state memories, in a read state and a compare state.
// one command is worked on at a time; cmd_stall is high until it is finished.
// registers are written over apb (total_iterations at 0, workers_in_use at 4)
// only while the block is idle: a rule on the user, the block does not enforce
// it. reset sets the registers to 1024 and 8 and empties the output register;
// the per-worker state is undefined until a start
module affinity_work_stealing_scheduler
	import awss_pkg::*;
#(
	parameter int MAX_WORKERS = 8,
	parameter int ITER_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// apb register port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [PADDR_W-1:0]                     paddr,
	input  logic [APB_DW-1:0]                      pwdata,
	output logic [APB_DW-1:0]                      prdata,
	output logic                                   pready,
	// command channel
	input  logic                                   cmd_valid,
	output logic                                   cmd_stall,
	input  logic                                   command,
	input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] worker_id,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] out_worker,
	output logic [ITER_BITS-1:0]                   chunk_first,
	output logic [ITER_BITS-1:0]                   chunk_end,
	output logic                                   all_done,
	output logic                                   last
);

	localparam int IW    = ITER_BITS;
	localparam int WID_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CNT_W = $clog2(MAX_WORKERS + 1);
	localparam int DW    = ITER_BITS + 1;
	localparam int DCW   = $clog2(DW + 1);
	localparam logic [7:0] MAXW8 = 8'(MAX_WORKERS);

	// configuration registers
	logic [IW-1:0]    total_iterations_q;
	logic [WIU_W-1:0] workers_in_use_q;
	logic             cfg_wr;

	// sequencer and datapath registers
	state_t           state_q, state_d, ret_q, ret_d;
	logic [IW-1:0]    each_q, each_d;
	logic [IW-1:0]    b_q, b_d;        // range begin, then chunk begin
	logic [IW-1:0]    l_q, l_d;        // range limit
	logic [IW-1:0]    my_rem_q, my_rem_d;
	logic [IW-1:0]    maxr_q, maxr_d;
	logic [IW-1:0]    steal_q, steal_d;
	logic [WID_W-1:0] w_q, w_d;
	logic [WID_W-1:0] me_q, me_d;
	logic [WID_W-1:0] find_q, find_d;

	// shared divider
	logic [DW-1:0]    div_acc_q;
	logic [WIU_W-1:0] div_rem_q;
	logic [DCW-1:0]   div_cnt_q;
	logic             div_go;
	logic [IW-1:0]    div_x;
	state_t           div_ret;
	logic [WIU_W:0]   div_sh, div_trial;
	logic             div_fits;
	logic [IW-1:0]    div_q;

	// per-worker state memories
	logic [IW-1:0]    rl_mem  [MAX_WORKERS];
	logic [IW-1:0]    rem_mem [MAX_WORKERS];
	logic [IW-1:0]    cb_mem  [MAX_WORKERS];
	logic [IW-1:0]    cl_mem  [MAX_WORKERS];
	logic [IW-1:0]    rd_rl_q, rd_rem_q, rd_cb_q, rd_cl_q;
	logic [WID_W-1:0] raddr, waddr;
	logic             we_rl, we_rem, we_cb, we_cl;
	logic [IW-1:0]    wd_rl, wd_rem, wd_cb, wd_cl;

	// output register
	logic             out_valid_q;
	logic [WID_W-1:0] out_worker_q;
	logic [IW-1:0]    chunk_first_q, chunk_end_q;
	logic             all_done_q, last_q;
	logic             out_free, out_load;
	logic [WID_W-1:0] o_worker;
	logic [IW-1:0]    o_first, o_end;
	logic             o_done, o_last;

	// derived values
	logic [7:0]       p8;
	logic [CNT_W-1:0] p_cnt;
	logic [WIU_W-1:0] p_div;
	logic             me_ok, w_last;
	logic [IW:0]      range_sum;
	logic [IW-1:0]    range_end, fin_raw, fin, fn_take, cb_sum;

	// ---------------------------------------------------------------
	// apb registers
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_iterations_q <= IW'(TOTAL_RESET);
			workers_in_use_q   <= WIU_W'(WORKERS_RESET);
		end else if (cfg_wr) begin
			case (paddr[PADDR_W-1:2])
				REG_TOTAL_ITER: total_iterations_q <= IW'(pwdata[15:0]);
				REG_WORKERS:    workers_in_use_q   <= pwdata[WIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_TOTAL_ITER: prdata = APB_DW'(total_iterations_q);
			REG_WORKERS:    prdata = APB_DW'(workers_in_use_q);
			default:        prdata = '0;
		endcase
	end

	// effective worker count: zero counts as one, clamped to the worker slots
	assign p8 = (workers_in_use_q == '0) ? 8'd1 :
		(({4'd0, workers_in_use_q} > MAXW8) ? MAXW8 : {4'd0, workers_in_use_q});
	assign p_cnt = p8[CNT_W-1:0];
	assign p_div = p8[WIU_W-1:0];

	assign me_ok  = CNT_W'(worker_id) < p_cnt;
	assign w_last = (CNT_W'(w_q) + CNT_W'(1)) == p_cnt;

	// range end of the current worker at start, clamped to the loop length
	assign range_sum = {1'b0, b_q} + {1'b0, each_q};
	assign range_end = (range_sum > {1'b0, total_iterations_q}) ?
		total_iterations_q : range_sum[IW-1:0];

	// chunk end, clamped to the range limit
	assign fin_raw = b_q + div_q;
	assign fin     = (fin_raw > l_q) ? l_q : fin_raw;
	assign fn_take = fin - b_q;
	assign cb_sum  = rd_cb_q + rd_cl_q;

	// ---------------------------------------------------------------
	// shared restoring divider: ceil(x / p) as (x + p - 1) / p
	// ---------------------------------------------------------------
	assign div_sh    = {div_rem_q, div_acc_q[DW-1]};
	assign div_trial = div_sh - {1'b0, p_div};
	assign div_fits  = !div_trial[WIU_W];
	assign div_q     = div_acc_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_acc_q <= {1'b0, div_x} + DW'(p_div) - DW'(1);
			div_rem_q <= '0;
			div_cnt_q <= DCW'(DW);
		end else if (state_q == ST_DIV) begin
			div_acc_q <= {div_acc_q[DW-2:0], div_fits};
			div_rem_q <= div_fits ? div_trial[WIU_W-1:0] : div_sh[WIU_W-1:0];
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// ---------------------------------------------------------------
	// state memories, one write and one read address a cycle
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (we_rl)  rl_mem[waddr]  <= wd_rl;
		if (we_rem) rem_mem[waddr] <= wd_rem;
		if (we_cb)  cb_mem[waddr]  <= wd_cb;
		if (we_cl)  cl_mem[waddr]  <= wd_cl;
	end

	always_ff @(posedge clk) begin
		rd_rl_q  <= rl_mem[raddr];
		rd_rem_q <= rem_mem[raddr];
		rd_cb_q  <= cb_mem[raddr];
		rd_cl_q  <= cl_mem[raddr];
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_ff @(posedge clk) begin
		each_q   <= each_d;
		b_q      <= b_d;
		l_q      <= l_d;
		my_rem_q <= my_rem_d;
		maxr_q   <= maxr_d;
		steal_q  <= steal_d;
		w_q      <= w_d;
		me_q     <= me_d;
		find_q   <= find_d;
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		each_d   = each_q;
		b_d      = b_q;
		l_d      = l_q;
		my_rem_d = my_rem_q;
		maxr_d   = maxr_q;
		steal_d  = steal_q;
		w_d      = w_q;
		me_d     = me_q;
		find_d   = find_q;
		div_go   = 1'b0;
		div_x    = '0;
		div_ret  = ST_IDLE;
		raddr    = find_q;
		waddr    = me_q;
		we_rl    = 1'b0;
		we_rem   = 1'b0;
		we_cb    = 1'b0;
		we_cl    = 1'b0;
		wd_rl    = l_q;
		wd_rem   = '0;
		wd_cb    = b_q;
		wd_cl    = '0;
		out_load = 1'b0;
		o_worker = me_q;
		o_first  = b_q;
		o_end    = fin;
		o_done   = 1'b0;
		o_last   = 1'b1;

		case (state_q)
			ST_IDLE: begin
				raddr = worker_id;
				if (cmd_valid) begin
					if (command == CMD_START) begin
						div_go  = 1'b1;
						div_x   = total_iterations_q;
						div_ret = ST_ST_EACH;
					end else if (me_ok) begin
						me_d    = worker_id;
						state_d = ST_FN_READ;
					end
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DCW'(1)) begin
					state_d = ret_q;
				end
			end
			// start: range size, then one range and first chunk per worker
			ST_ST_EACH: begin
				each_d  = div_q;
				b_d     = '0;
				w_d     = '0;
				state_d = ST_ST_RANGE;
			end
			ST_ST_RANGE: begin
				l_d     = range_end;
				div_go  = 1'b1;
				div_x   = range_end - b_q;
				div_ret = ST_ST_EMIT;
			end
			ST_ST_EMIT: begin
				if (out_free) begin
					waddr    = w_q;
					we_rl    = 1'b1;
					we_rem   = 1'b1;
					we_cb    = 1'b1;
					we_cl    = 1'b1;
					wd_rem   = (l_q - b_q) - div_q;
					wd_cl    = div_q;
					out_load = 1'b1;
					o_worker = w_q;
					o_end    = fin_raw;
					o_last   = w_last;
					if (w_last) begin
						state_d = ST_IDLE;
					end else begin
						w_d     = w_q + WID_W'(1);
						b_d     = l_q;
						state_d = ST_ST_RANGE;
					end
				end
			end
			// finished: next chunk of the own range
			ST_FN_READ: begin
				l_d      = rd_rl_q;
				my_rem_d = rd_rem_q;
				b_d      = cb_sum;
				div_go   = 1'b1;
				div_x    = rd_rem_q;
				div_ret  = ST_FN_CHUNK;
			end
			ST_FN_CHUNK: begin
				if (fin > b_q) begin
					if (out_free) begin
						we_cb    = 1'b1;
						we_cl    = 1'b1;
						we_rem   = 1'b1;
						wd_cl    = fn_take;
						wd_rem   = (my_rem_q > fn_take) ? (my_rem_q - fn_take) : '0;
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					// own range used up: look for the busiest worker
					we_cb   = 1'b1;
					we_cl   = 1'b1;
					wd_cl   = div_q;
					w_d     = '0;
					maxr_d  = '0;
					find_d  = me_q;
					state_d = ST_SR_READ;
				end
			end
			ST_SR_READ: begin
				raddr   = w_q;
				state_d = ST_SR_CMP;
			end
			ST_SR_CMP: begin
				if (rd_rem_q > maxr_q) begin
					maxr_d = rd_rem_q;
					find_d = w_q;
				end
				if (w_last) begin
					state_d = ST_SR_END;
				end else begin
					w_d     = w_q + WID_W'(1);
					state_d = ST_SR_READ;
				end
			end
			ST_SR_END: begin
				if (find_q == me_q) begin
					if (out_free) begin
						out_load = 1'b1;
						o_first  = '0;
						o_end    = '0;
						o_done   = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					// victim state is read while the steal size is divided
					div_go  = 1'b1;
					div_x   = maxr_q;
					div_ret = ST_SL_FIND;
				end
			end
			// steal: take the block after the victim's current chunk
			ST_SL_FIND: begin
				steal_d = div_q;
				b_d     = cb_sum;
				l_d     = cb_sum + div_q;
				waddr   = find_q;
				we_rem  = 1'b1;
				we_cl   = 1'b1;
				wd_rem  = (maxr_q > div_q) ? (maxr_q - div_q) : '0;
				wd_cl   = rd_cl_q + div_q;
				div_go  = 1'b1;
				div_x   = div_q;
				div_ret = ST_SL_EMIT;
			end
			ST_SL_EMIT: begin
				if (out_free) begin
					we_rl    = 1'b1;
					we_rem   = 1'b1;
					we_cb    = 1'b1;
					we_cl    = 1'b1;
					wd_cl    = div_q;
					wd_rem   = my_rem_q + (steal_q - div_q);
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (div_go) begin
			state_d = ST_DIV;
			ret_d   = div_ret;
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_worker_q  <= o_worker;
			chunk_first_q <= o_first;
			chunk_end_q   <= o_end;
			all_done_q    <= o_done;
			last_q        <= o_last;
		end
	end

	assign res_valid   = out_valid_q;
	assign out_worker  = out_worker_q;
	assign chunk_first = chunk_first_q;
	assign chunk_end   = chunk_end_q;
	assign all_done    = all_done_q;
	assign last        = last_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// a new result word never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result word overwritten while stalled");

	// the divider is left only after its last quotient bit
	a_div_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && state_d != ST_DIV) |-> div_cnt_q == DCW'(1))
		else $error("divider left early");

	// a taken start word always makes the block busy, so cmd_stall rises after it
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && command == CMD_START) |=> cmd_stall)
		else $error("start word finished at once");

	// the busiest-worker search stays inside the workers in use
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SR_CMP) |-> (CNT_W'(w_q) < p_cnt))
		else $error("search beyond workers in use");

endmodule

### tb/sv/affinity_work_stealing_scheduler_tb.sv
// self-checking testbench of the affinity work-stealing chunk scheduler
`timescale 1ns / 100ps

module affinity_work_stealing_scheduler_tb;
	import awss_pkg::*;

	localparam int WB = 3;             // worker index bits
	localparam int IB = 16;            // iteration bits
	localparam int NW = 8;             // worker slots
	localparam int unsigned IMASK = (1 << IB) - 1;
	// longest quiet spell of a correct run: a start with eight workers plus stall
	// streaks, or a settling pause and the register accesses after it
	localparam int QUIET_LIMIT = 5000;
	// cycles let pass once nothing is due, covering the longest command
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic          cmd;
		logic [WB-1:0] wid;
	} cmd_word_t;

	typedef struct packed {
		logic [WB-1:0] worker;
		logic [IB-1:0] first;
		logic [IB-1:0] fin;
		logic          done;
		logic          last;
	} chunk_word_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	logic              command   = CMD_START;
	logic [WB-1:0]     worker_id = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [WB-1:0]     out_worker;
	logic [IB-1:0]     chunk_first;
	logic [IB-1:0]     chunk_end;
	logic              all_done;
	logic              last;

	affinity_work_stealing_scheduler dut (.*);

	// words waiting to be sent, and chunk words the block still owes
	cmd_word_t   cmd_words[$];
	chunk_word_t due_chunks[$];

	// shadow of the register file
	logic [IB-1:0]    cfg_total   = 16'(TOTAL_RESET);
	logic [WIU_W-1:0] cfg_workers = WIU_W'(WORKERS_RESET);

	// shadow of the per-worker scheduling state
	int unsigned span_begin[NW];
	int unsigned span_limit[NW];
	int unsigned work_left[NW];
	int unsigned piece_begin[NW];
	int unsigned piece_limit[NW];
	int unsigned piece_len[NW];

	// idling controls, one pair per idling mode
	int idle_send[4]  = '{0, 57, 0, 33};
	int idle_stall[4] = '{0, 0, 57, 33};
	int send_idle_pct = 0;
	int stall_pct     = 0;
	logic hold_words  = 1'b0;

	int mismatches    = 0;
	int words_taken   = 0;
	int starts_taken  = 0;
	int results_seen  = 0;
	int steals_due    = 0;
	int dones_due     = 0;
	int settings      = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned live_workers(logic [WIU_W-1:0] v);
		if (v < 1)
			return 1;
		if (v > NW)
			return NW;
		return v;
	endfunction

	function automatic int unsigned div_up(int unsigned x, int unsigned d);
		return (x + d - 1) / d;
	endfunction

	function automatic int unsigned sat_minus(int unsigned a, int unsigned b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic void owe(int unsigned w, int unsigned first, int unsigned fin,
			bit done, bit lst);
		chunk_word_t c;
		c.worker = WB'(w);
		c.first  = IB'(first);
		c.fin    = IB'(fin);
		c.done   = done;
		c.last   = lst;
		due_chunks.push_back(c);
	endfunction

	// works out the chunk words one accepted command word causes
	function automatic void assign_chunks(logic cmd, logic [WB-1:0] wid);
		int unsigned p, n, me, each, b, l, len, cb, fin, maxr, steal, victim;
		p = live_workers(cfg_workers);
		n = cfg_total;
		me = wid;
		if (cmd == CMD_START) begin
			// equal contiguous ranges, each worker's first piece of its own range
			each = div_up(n, p);
			for (int unsigned w = 0; w < p; w++) begin
				b = w * each;
				l = (w + 1) * each;
				if (b > n)
					b = n;
				if (l > n)
					l = n;
				span_begin[w]  = b;
				span_limit[w]  = l;
				len            = div_up(l - b, p);
				work_left[w]   = (l - b) - len;
				piece_len[w]   = len;
				piece_begin[w] = b;
				piece_limit[w] = (b + len) & IMASK;
				owe(w, b, piece_limit[w], 1'b0, w + 1 == p);
			end
			return;
		end
		// a worker beyond the live count gets nothing back
		if (me >= p)
			return;
		cb  = (piece_begin[me] + piece_len[me]) & IMASK;
		len = div_up(work_left[me], p);
		fin = (cb + len) & IMASK;
		if (fin > span_limit[me])
			fin = span_limit[me];
		piece_begin[me] = cb;
		piece_len[me]   = len;
		piece_limit[me] = fin;
		if (fin > cb) begin
			piece_len[me] = fin - cb;
			work_left[me] = sat_minus(work_left[me], fin - cb);
			owe(me, cb, fin, 1'b0, 1'b1);
			return;
		end
		// own range used up: busiest worker, lowest index on ties
		maxr   = 0;
		victim = me;
		for (int unsigned w = 0; w < p; w++) begin
			if (work_left[w] > maxr) begin
				maxr   = work_left[w];
				victim = w;
			end
		end
		if (victim == me) begin
			dones_due++;
			owe(me, 0, 0, 1'b1, 1'b1);
			return;
		end
		steals_due++;
		steal = div_up(maxr, p);
		span_begin[me]    = (piece_begin[victim] + piece_len[victim]) & IMASK;
		span_limit[me]    = (span_begin[me] + steal) & IMASK;
		work_left[victim] = sat_minus(work_left[victim], steal);
		piece_len[victim] = (piece_len[victim] + steal) & IMASK;
		len = div_up(steal, p);
		piece_len[me]   = len;
		piece_begin[me] = span_begin[me];
		fin = (piece_begin[me] + len) & IMASK;
		if (fin > span_limit[me])
			fin = span_limit[me];
		piece_limit[me] = fin;
		work_left[me]   = (work_left[me] + (steal - len)) & IMASK;
		owe(me, piece_begin[me], fin, 1'b0, 1'b1);
	endfunction

	function automatic void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got)
			flag($sformatf("result %0d %s expected %0d got %0d", results_seen, field,
				want, got));
	endfunction

	// command driver: the head of cmd_words is the word on the port
	always @(posedge clk) begin : drive_words
		logic took;
		took = 1'b0;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				assign_chunks(command, worker_id);
				words_taken++;
				if (command == CMD_START)
					starts_taken++;
				void'(cmd_words.pop_front());
				took = 1'b1;
			end
			// a stalled word holds; otherwise maybe idle, then offer the next one
			if (!cmd_valid || took) begin
				if (cmd_words.size() != 0 && !hold_words &&
						$urandom_range(99) >= send_idle_pct) begin
					cmd_valid <= 1'b1;
					command   <= cmd_words[0].cmd;
					worker_id <= cmd_words[0].wid;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: every taken word against the oldest chunk owed
	always @(posedge clk) begin : watch_results
		chunk_word_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (due_chunks.size() == 0) begin
					flag($sformatf("result %0d arrived with nothing owed (worker %0d)",
						results_seen, out_worker));
				end else begin
					want = due_chunks.pop_front();
					check_field("out_worker", want.worker, out_worker);
					check_field("chunk_first", want.first, chunk_first);
					check_field("chunk_end", want.fin, chunk_end);
					check_field("all_done", want.done, all_done);
					check_field("last", want.last, last);
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on spells in which neither channel moves a word
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void queue_word(logic cmd, logic [WB-1:0] wid);
		cmd_word_t c;
		c.cmd = cmd;
		c.wid = wid;
		cmd_words.push_back(c);
	endfunction

	// a start, then mostly finished words from live workers; some noise and restarts
	function automatic void queue_random(int unsigned want, int unsigned p_eff);
		int unsigned counted, r;
		logic [WB-1:0] wid;
		queue_word(CMD_START, WB'($urandom));
		counted = 1;
		while (counted < want) begin
			r = $urandom_range(99);
			if (r < 5) begin
				queue_word(CMD_START, WB'($urandom));
				counted++;
			end else if (r < 15) begin
				wid = WB'($urandom);
				queue_word(CMD_FINISH, wid);
				if (wid < p_eff)
					counted++;
			end else begin
				queue_word(CMD_FINISH, WB'($urandom_range(p_eff - 1)));
				counted++;
			end
		end
	endfunction

	// apb read with the value checked against the shadow
	task automatic check_reg(reg_idx_t idx, logic [APB_DW-1:0] want);
		logic [APB_DW-1:0] seen;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		seen = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (seen !== want)
			flag($sformatf("register %0d read back %0d, expected %0d", idx, seen, want));
	endtask

	task automatic set_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_TOTAL_ITER)
			cfg_total = value[IB-1:0];
		else
			cfg_workers = value[WIU_W-1:0];
		check_reg(idx, (idx == REG_TOTAL_ITER) ? APB_DW'(value[IB-1:0]) :
			APB_DW'(value[WIU_W-1:0]));
	endtask

	// wait until every owed word is in, then give the block time to go idle
	task automatic settle();
		while (cmd_words.size() != 0 || cmd_valid || due_chunks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// new register setting and idling pattern, only once the block is idle
	task automatic new_phase(int unsigned total, int unsigned workers, int mode);
		settle();
		set_reg(REG_TOTAL_ITER, total);
		set_reg(REG_WORKERS, workers);
		settings++;
		send_idle_pct <= idle_send[mode];
		stall_pct     <= idle_stall[mode];
	endtask

	initial begin : run_test
		int unsigned total, workers;
		for (int w = 0; w < NW; w++) begin
			span_begin[w]  = 0;
			span_limit[w]  = 0;
			work_left[w]   = 0;
			piece_begin[w] = 0;
			piece_limit[w] = 0;
			piece_len[w]   = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		check_reg(REG_TOTAL_ITER, APB_DW'(TOTAL_RESET));
		check_reg(REG_WORKERS, APB_DW'(WORKERS_RESET));

		// reset setting; the first start fills the state of all eight workers
		queue_word(CMD_START, 3'd0);
		queue_word(CMD_FINISH, 3'd0);
		queue_word(CMD_FINISH, 3'd7);

		// single iteration, single worker: done at once, high ids ignored
		new_phase(1, 1, 0);
		queue_word(CMD_START, 3'd7);
		queue_word(CMD_FINISH, 3'd0);
		queue_word(CMD_FINISH, 3'd7);
		queue_word(CMD_FINISH, 3'd0);

		// longest loop, last range cut at the loop end
		new_phase(IMASK, 8, 0);
		queue_word(CMD_START, 3'd0);
		queue_word(CMD_FINISH, 3'd7);
		queue_word(CMD_FINISH, 3'd3);

		// three workers on twenty: worker 0 runs dry and steals from worker 1
		new_phase(20, 3, 0);
		queue_word(CMD_START, 3'd0);
		repeat (4) queue_word(CMD_FINISH, 3'd0);
		queue_word(CMD_FINISH, 3'd1);
		queue_word(CMD_FINISH, 3'd5);

		// worker count of zero acts as one
		new_phase(5, 0, 0);
		queue_word(CMD_START, 3'd0);
		queue_word(CMD_FINISH, 3'd0);
		queue_word(CMD_FINISH, 3'd0);

		// worker count above eight acts as eight; ranges past the end are empty
		new_phase(3, 12, 0);
		queue_word(CMD_START, 3'd0);
		queue_word(CMD_FINISH, 3'd5);

		// random part, idling pattern rotating per phase
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin total = $urandom_range(1, 64);  workers = 8; end
				1: begin total = $urandom_range(1, 300); workers = $urandom_range(1, 8); end
				2: begin total = $urandom_range(1, 40);  workers = 1; end
				3: begin total = IMASK;                  workers = 8; end
				4: begin total = $urandom_range(1, 100); workers = $urandom_range(2, 4); end
				5: begin total = $urandom_range(1, 30);  workers = 0; end
				6: begin total = $urandom_range(1, 200); workers = 15; end
				default: begin
					total   = $urandom_range(1, 500);
					workers = $urandom_range(1, 8);
				end
			endcase
			new_phase(total, workers, ph % 4);
			queue_random(38, live_workers(WIU_W'(workers)));
			// halfway through, hold the sender until every owed word is back
			while (cmd_words.size() > 19)
				@(posedge clk);
			hold_words <= 1'b1;
			@(posedge clk);
			while (cmd_valid || due_chunks.size() != 0)
				@(posedge clk);
			hold_words <= 1'b0;
		end

		settle();
		$display("covered %0d command words (%0d starts) over %0d register settings",
			words_taken, starts_taken, settings);
		$display("checked %0d result words, %0d steals and %0d done answers among them",
			results_seen, steals_due, dones_due);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
